// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/khtbl_pkg.sv =====
`default_nettype none

package khtbl_pkg;

  // Table geometry
  localparam int SLOTS       = 16;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 32;
  localparam int FIELD_BITS  = 32;

  // Stored widths: request fields are cut to the configured widths
  localparam int KEY_W    = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
  localparam int HANDLE_W = (HANDLE_BITS < FIELD_BITS) ? HANDLE_BITS : FIELD_BITS;

  // Request codes
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [SLOTS-1:0]    slot_vec_t;

  // Lookup result handed from the match logic to the table
  typedef struct packed {
    logic      hit;
    slot_vec_t hit_oh;
    logic      full;
    slot_vec_t free_oh;
  } match_t;

endpackage

`default_nettype wire

// ===== hdl/keyed_handler_table.sv =====
`default_nettype none
`include "assert_macros.svh"

// Keyed handler table: 16 slots of key, handler and argument. A request is
// taken on any cycle with start_i high; busy_o stays low, so one request
// per cycle is sustained. The request is captured in an input register; the
// key compare and the lowest-free search then work on it, and the result is
// held in a result register, from which it is taken. It is shown for one
// cycle only, with done_o high. The receiver cannot stall: it must take every
// result as it comes. Requests see the table as left by every earlier request.
module keyed_handler_table (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [1:0]  kind_i,
  input  wire  [31:0] key_i,
  input  wire  [31:0] handler_i,
  input  wire  [31:0] argument_i,
  output logic        done_o,
  output logic        status_o,
  output logic [31:0] found_handler_o,
  output logic [31:0] found_argument_o
);
  import khtbl_pkg::*;

  // Input register
  logic    req_vld_q;
  kind_e   kind_q;
  key_t    key_q;
  handle_t handler_q;
  handle_t argument_q;

  // Table storage
  slot_vec_t valid_q, valid_d;
  key_t      keys_q     [SLOTS];
  handle_t   handlers_q [SLOTS];
  handle_t   args_q     [SLOTS];

  match_t    match;
  logic      add_wr;
  handle_t   rd_handler;
  handle_t   rd_argument;

  // Result register
  logic        done_q;
  logic        status_d, status_q;
  logic [31:0] fh_d, fh_q;
  logic [31:0] fa_d, fa_q;

  assign busy_o = 1'b0;

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      kind_q     <= kind_e'(kind_i);
      key_q      <= key_i[KEY_W-1:0];
      handler_q  <= handler_i[HANDLE_W-1:0];
      argument_q <= argument_i[HANDLE_W-1:0];
    end
  end

  khtbl_match u_match (
    .valid_i (valid_q),
    .keys_i  (keys_q),
    .key_i   (key_q),
    .match_o (match)
  );

  // Read the handles of the matching slot through a one-hot select
  always_comb begin
    rd_handler  = '0;
    rd_argument = '0;
    for (int s = 0; s < SLOTS; s++) begin
      rd_handler  = rd_handler  | (handlers_q[s] & {HANDLE_W{match.hit_oh[s]}});
      rd_argument = rd_argument | (args_q[s]     & {HANDLE_W{match.hit_oh[s]}});
    end
  end

  // Decide the result and the table update
  always_comb begin
    valid_d  = valid_q;
    add_wr   = 1'b0;
    status_d = 1'b1;
    fh_d     = '0;
    fa_d     = '0;
    if (req_vld_q) begin
      case (kind_q)
        KIND_ADD: begin
          if (match.hit) begin
            status_d = 1'b0;
          end else if (!match.full) begin
            add_wr   = 1'b1;
            valid_d  = valid_q | match.free_oh;
            status_d = 1'b0;
          end
        end
        KIND_GET: begin
          if (match.hit) begin
            status_d = 1'b0;
            fh_d     = FIELD_BITS'(rd_handler);
            fa_d     = FIELD_BITS'(rd_argument);
          end
        end
        KIND_REMOVE: begin
          if (match.hit) begin
            valid_d  = valid_q & ~match.hit_oh;
            status_d = 1'b0;
          end
        end
        default: begin
          status_d = 1'b1;
        end
      endcase
    end
  end

  // Hold the valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Write a new entry into the lowest free slot
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (add_wr && match.free_oh[s]) begin
        keys_q[s]     <= key_q;
        handlers_q[s] <= handler_q;
        args_q[s]     <= argument_q;
      end
    end
  end

  // Register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      status_q <= status_d;
      fh_q     <= fh_d;
      fa_q     <= fa_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign found_handler_o  = fh_q;
  assign found_argument_o = fa_q;

  // Keys are unique among valid slots, so at most one slot matches
  `ASSERT_PROP(a_hit_onehot0, clk_i, rst_ni, $onehot0(match.hit_oh), "several slots hold one key")
  // A free slot is offered exactly when the table is not full
  `ASSERT_PROP(a_free_slot, clk_i, rst_ni, match.full != $onehot(match.free_oh), "free slot pick wrong")
  // A failed request returns zero handles
  `ASSERT_NEVER(a_fail_zero, clk_i, rst_ni, done_o && status_o && ((found_handler_o != '0) || (found_argument_o != '0)), "failed request returned handles")
  // A successful remove clears the matching slot
  `ASSERT_PROP(a_remove_clears, clk_i, rst_ni, (req_vld_q && (kind_q == KIND_REMOVE) && match.hit) |=> ((valid_q & $past(match.hit_oh)) == '0), "remove left slot valid")

endmodule

`default_nettype wire

// ===== hdl/khtbl_match.sv =====
`default_nettype none

module khtbl_match (
  input  khtbl_pkg::slot_vec_t valid_i,
  input  khtbl_pkg::key_t      keys_i [khtbl_pkg::SLOTS],
  input  khtbl_pkg::key_t      key_i,
  output khtbl_pkg::match_t    match_o
);
  import khtbl_pkg::*;

  slot_vec_t hit_oh;

  // Compare the key against every valid slot at once
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit_oh[s] = valid_i[s] && (keys_i[s] == key_i);
    end
  end

  // Isolate the lowest free slot; wraps to zero when every slot is taken
  assign match_o.hit_oh  = hit_oh;
  assign match_o.hit     = |hit_oh;
  assign match_o.full    = &valid_i;
  assign match_o.free_oh = ~valid_i & (valid_i + SLOTS'(1));

endmodule

`default_nettype wire

// ===== sim/tb_keyed_handler_table.sv =====
`timescale 1ns / 100ps

module tb_keyed_handler_table;
  import khtbl_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE = 24;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic        status;
    logic [31:0] found_handler;
    logic [31:0] found_argument;
  } reply_t;

  // Mirror of the slot table and the replies still owed by the block
  class slot_table_mirror;
    bit      occupied [SLOTS];
    key_t    keys     [SLOTS];
    handle_t handlers [SLOTS];
    handle_t arguments[SLOTS];
    reply_t  awaited[$];
    int      errors;

    // Apply one accepted request to the mirror and queue its reply
    function void note_request(logic [1:0] kind, logic [31:0] key,
                               logic [31:0] handler, logic [31:0] argument);
      reply_t r;
      key_t   k;
      int     hit;
      int     spare;
      r = '0;
      r.status = 1'b1;
      k = key_t'(key);
      hit = -1;
      spare = -1;
      for (int s = 0; s < SLOTS; s++) begin
        if (occupied[s] && keys[s] == k && hit < 0) hit = s;
        if (!occupied[s] && spare < 0) spare = s;
      end
      case (kind)
        KIND_ADD: begin
          // keep the old entry on a duplicate key
          if (hit >= 0) begin
            r.status = 1'b0;
          end else if (spare >= 0) begin
            occupied[spare]  = 1'b1;
            keys[spare]      = k;
            handlers[spare]  = handle_t'(handler);
            arguments[spare] = handle_t'(argument);
            r.status = 1'b0;
          end
        end
        KIND_GET: begin
          if (hit >= 0) begin
            r.status = 1'b0;
            r.found_handler  = handlers[hit];
            r.found_argument = arguments[hit];
          end
        end
        KIND_REMOVE: begin
          if (hit >= 0) begin
            occupied[hit] = 1'b0;
            r.status = 1'b0;
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    // Compare a reply with the oldest one owed
    function void check_result(logic status, logic [31:0] fh, logic [31:0] fa);
      reply_t r;
      if (awaited.size() == 0) begin
        $display("%0t: reply with none owed: status %0d handler %h argument %h",
                 $time, status, fh, fa);
        errors++;
        return;
      end
      r = awaited.pop_front();
      if (status !== r.status) begin
        $display("%0t: status expected %0d, got %0d", $time, r.status, status);
        errors++;
      end
      if (fh !== r.found_handler) begin
        $display("%0t: found_handler expected %h, got %h", $time, r.found_handler, fh);
        errors++;
      end
      if (fa !== r.found_argument) begin
        $display("%0t: found_argument expected %h, got %h", $time, r.found_argument, fa);
        errors++;
      end
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        $display("%0t: %0d replies never arrived", $time, awaited.size());
        errors += awaited.size();
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  kind_i;
  logic [31:0] key_i;
  logic [31:0] handler_i;
  logic [31:0] argument_i;
  logic        done_o;
  logic        status_o;
  logic [31:0] found_handler_o;
  logic [31:0] found_argument_o;

  slot_table_mirror mirror;
  logic [31:0] key_pool[POOL_SIZE];
  int          cycle_count;

  keyed_handler_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .handler_i       (handler_i),
    .argument_i      (argument_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_handler_o (found_handler_o),
    .found_argument_o(found_argument_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abandon a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Watch both sides at each edge: replies first, then the request taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) mirror.check_result(status_o, found_handler_o, found_argument_o);
      if (start_i && busy_o === 1'b0) mirror.note_request(kind_i, key_i, handler_i, argument_i);
    end
  end

  // Drive one request, idling first at random, and hold it until taken
  task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
                              input logic [31:0] handler, input logic [31:0] argument,
                              input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    handler_i  <= handler;
    argument_i <= argument;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Drop start and hold off until every owed reply has come back
  task automatic drain();
    start_i <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
  endtask

  // Mostly keys from a small pool so that hits are common
  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // One random request, with the add share steering the table's fill level
  task automatic random_request(input int add_w, input int idle_pct);
    logic [1:0] kind;
    int         r;
    r = $urandom_range(99);
    if (r < 3) kind = KIND_UNUSED;
    else if (r < 3 + add_w) kind = KIND_ADD;
    else if (r < 3 + add_w + (97 - add_w) / 2) kind = KIND_GET;
    else kind = KIND_REMOVE;
    send_request(kind, pick_key(), $urandom, $urandom, idle_pct);
  endtask

  initial begin
    int idle_pcts[4];
    idle_pcts = '{0, 80, 0, 21};
    mirror = new();
    cycle_count = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    kind_i = KIND_ADD;
    key_i = '0;
    handler_i = '0;
    argument_i = '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: lookups miss
    send_request(KIND_GET, 32'h0000_0000, 32'h0, 32'h0, 0);
    send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0, 0);
    // Extreme keys and handles
    send_request(KIND_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    send_request(KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_request(KIND_GET, 32'h0000_0000, 32'h1111_1111, 32'h2222_2222, 0);
    // Duplicate add keeps the stored handles
    send_request(KIND_ADD, 32'h0000_0000, 32'h1234_5678, 32'h9ABC_DEF0, 0);
    send_request(KIND_GET, 32'h0000_0000, 32'h0, 32'h0, 0);
    // Unused request code
    send_request(KIND_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(KIND_REMOVE, 32'h0000_0000, 32'h0, 32'h0, 0);
    send_request(KIND_GET, 32'h0000_0000, 32'h0, 32'h0, 0);
    // Fill every slot, then add one too many and a duplicate while full
    for (int i = 2; i < 2 + SLOTS - 1; i++) send_request(KIND_ADD, key_pool[i], $urandom, $urandom, 0);
    send_request(KIND_ADD, 32'h5A5A_A5A5, 32'hDEAD_0001, 32'hDEAD_0002, 0);
    send_request(KIND_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0, 0);
    drain();

    // Random phases, each with shifting add share, and a full drain between
    foreach (idle_pcts[p]) begin
      for (int c = 0; c < 3; c++) begin
        int add_w;
        add_w = $urandom_range(15, 60);
        repeat (150) random_request(add_w, idle_pcts[p]);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mirror.close_out();
    if (mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
